[design/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is asserted.
`define FBC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Concurrent assertion, checked at every edge including reset.
`define FBC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[design/fbc64_pkg.sv]
// Types, constants and functions of the 64-bit Feistel block cipher.
package fbc64_pkg;

    localparam int HALF_W   = 32;
    localparam int BLOCK_W  = 64;
    localparam int CFG_IDX_W = 8;
    localparam int MAX_ROUNDS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

    localparam logic [31:0] KEY_DELTA = 32'h9E37_79B9;
    localparam logic [7:0]  SBOX_XOR  = 8'h5A;

    typedef struct packed {
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } half_pair_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        logic [63:0] w;
        w = {v, v} << (n & 31);
        return w[63:32];
    endfunction

    // v*17 mod 256 is v + (v << 4)
    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] t;
        t = 8'(v + {v[3:0], 4'b0000}) ^ {3'b000, v[7:3]} ^ SBOX_XOR;
        return {t[5:0], t[7:6]} ^ {t[2:0], t[7:3]};
    endfunction

endpackage

[design/fbc64_round.sv]
// One Feistel round: (L, R) -> (R, L xor F(R, k)).
module fbc64_round (
    input  fbc64_pkg::half_pair_t  din,
    input  logic [31:0]            rkey,
    output fbc64_pkg::half_pair_t  dout
);
    import fbc64_pkg::*;

    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] f;

    always_comb begin
        x = din.right ^ rkey;
        for (int i = 0; i < 4; i++) begin
            y[8*i +: 8] = sbox(x[8*i +: 8]);
        end
        f = rotl32(y, 11) ^ rotl32(y, 5);
        dout.left  = din.right;
        dout.right = din.left ^ f;
    end

endmodule

[design/feistel_block_cipher_64_unit.sv]
// Top level of the 64-bit Feistel block cipher, one round per pipeline stage.
//
// Usage:
//   Key: write key_high (index 0) and key_low (index 1) on the cfg channel
//   while the pipeline is empty; cfg_ready is always high and writes to
//   other indexes are dropped. Round keys are derived from the key
//   registers by logic, so a block may follow the last key write at once.
//   Input: one plaintext block per s_ transaction, byte 0 in the top bits.
//   Output: one ciphertext block per m_ transaction, in input order.
//   Path: from s_ acceptance to m_tvalid a block passes an input
//   register, one register per round and an output register.
//   Throughput: one block per cycle while m_tready is high, one round a stage.
//   Stall: each stage holds while its successor is full and stalled; an
//   empty stage still accepts, so s_tready drops only when every stage is
//   full and m_tready is low.
//   Reset: aresetn low clears all valid bits and both key registers.
module feistel_block_cipher_64_unit #(
    parameter int ROUNDS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: plain_block[63:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,
    // tdata: cipher_block[63:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbc64_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                         cfg_data
);
    import fbc64_pkg::*;

    localparam int NST = ROUNDS + 2;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [31:0] rk [ROUNDS];

    logic        valid_reg [NST];
    half_pair_t  data_reg  [NST];
    logic        valid_next [NST];
    half_pair_t  data_next  [NST];
    logic        ready [NST+1];
    half_pair_t  rnd_out [ROUNDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end else if (cfg_index == REG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end
        end
    end

    // key schedule: one xor step per round, taking turns over the four key words
    always_comb begin
        logic [31:0] kw [4];
        logic [31:0] t;
        kw[0] = key_high_reg[63:32];
        kw[1] = key_high_reg[31:0];
        kw[2] = key_low_reg[63:32];
        kw[3] = key_low_reg[31:0];
        for (int r = 0; r < ROUNDS; r++) begin
            t = rotl32(kw[r & 3], r & 7) ^ 32'(r * KEY_DELTA);
            rk[r] = t;
            kw[r & 3] = kw[r & 3] ^ t;
        end
    end

    generate
        for (genvar g = 0; g < ROUNDS; g++) begin : g_round
            fbc64_round u_round (
                .din       (data_reg[g]),
                .rkey      (rk[g]),
                .dout      (rnd_out[g])
            );
        end
    endgenerate

    always_comb begin
        ready[NST] = m_tready;
        for (int i = NST - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = s_tvalid;
        data_next[0]  = half_pair_t'(s_tdata);
        for (int i = 1; i <= ROUNDS; i++) begin
            valid_next[i] = valid_reg[i-1];
            data_next[i]  = rnd_out[i-1];
        end
        valid_next[NST-1] = valid_reg[NST-2];
        data_next[NST-1]  = data_reg[NST-2];
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NST; i++) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ready[i]) begin
                valid_reg[i] <= valid_next[i];
            end
            if (ready[i]) begin
                data_reg[i] <= data_next[i];
            end
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = {data_reg[NST-1].right, data_reg[NST-1].left};

endmodule

[design/fbc64_checker.sv]
// Port-level checks for the Feistel block cipher top level.
`include "assert_macros.svh"

module fbc64_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [63:0]                     m_tdata,
    input logic                            cfg_ready
);

    `FBC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `FBC_ASSERT(a_stall_src, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)
    `FBC_ASSERT(a_cfg_ready, aclk, aresetn, cfg_ready)
    `FBC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready)

endmodule

bind feistel_block_cipher_64_unit fbc64_checker u_fbc64_checker (.*);
